[hw/rtl/mls_pkg.sv]
`default_nettype none
package mls_pkg;

  // field widths
  localparam int unsigned LEVEL_W = 24;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned ACC_W   = LEVEL_W + FRAC_W;
  localparam int unsigned DUR_W   = 16;
  localparam int unsigned SPM_W   = 8;
  localparam int unsigned CNT_W   = DUR_W + SPM_W;
  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned CHAN_MAX = 4;
  // difference of two accumulator values needs one more bit
  localparam int unsigned DIV_W   = ACC_W + 1;

  localparam logic [SPM_W-1:0] SPM_RESET = 8'd48;

  // request kinds
  localparam logic REQ_RETARGET = 1'b0;
  localparam logic REQ_TICK     = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TICK,
    ST_DIV
  } mls_state_e;

  // controller to datapath
  typedef struct packed {
    logic latch;       // capture the incoming word
    logic set_target;  // store the new destination
    logic jump;        // zero-length ramp: go to destination at once
    logic div_start;   // start the step division
    logic set_step;    // store quotient and ramp length
    logic tick;        // advance the channel and load the output word
  } mls_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic chan_ok;
    logic n_zero;
    logic div_done;
    logic out_free;
  } mls_sts_t;

endpackage
`default_nettype wire

[hw/rtl/multichannel_linear_slew.sv]
`default_nettype none
// Multichannel linear ramp generator.
// Input stream (s_axis): tuser selects the request: retarget (0) or tick (1).
// A retarget stores a channel's destination and ramp time in ms; the ramp
// spans duration_ms * samples_per_ms ticks and gives no output word. A tick
// advances one channel by one sample and returns one output word with the
// channel, its 24-bit level and tlast high on the tick that ends a ramp.
// Words for channels at or beyond NUM_CHANNELS are dropped silently.
// Timing: one word at a time. A tick passes decode and the tick state,
// which loads the output word once the output register has room; the next
// word is accepted back in idle. A retarget with a nonzero ramp waits in
// the division state for the 41-step restoring divider that forms the
// per-sample step; a zero-length ramp or dropped word returns from decode.
// Reset: all channels idle at level zero, samples_per_ms returns to 48.
// The configuration port is always ready; write it only while idle.
// Output stall: a finished word waits in the output register while the
// next input word is accepted; a following tick holds until it drains.
module multichannel_linear_slew #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input words
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [47:0] s_axis_tdata,   // channel[1:0], target_level[25:2], duration_ms[41:26]
  input  wire         s_axis_tuser,   // req_type
  // output words
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_channel[1:0], level[25:2]
  output logic        m_axis_tlast,   // arrived
  // samples_per_ms register
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [7:0]  cfg_data_i
);
  import mls_pkg::*;

  mls_cmd_t            cmd;
  mls_sts_t            sts;
  logic [CHAN_W-1:0]   out_chan;
  logic [LEVEL_W-1:0]  out_level;

  assign cfg_ready_o = 1'b1;

  mls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mls_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (s_axis_tuser),
    .chan_i        (s_axis_tdata[1:0]),
    .target_i      (s_axis_tdata[25:2]),
    .dur_i         (s_axis_tdata[41:26]),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_chan_o    (out_chan),
    .out_level_o   (out_level),
    .out_arrived_o (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, out_level, out_chan};

endmodule
`default_nettype wire

[hw/rtl/mls_div.sv]
`default_nettype none
module mls_div (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [mls_pkg::DIV_W-1:0]     dividend_i,  // magnitude
  input  wire                           negate_i,
  input  wire  [mls_pkg::CNT_W-1:0]     divisor_i,
  output logic                          done_o,
  output logic [mls_pkg::ACC_W-1:0]     quot_o
);
  import mls_pkg::*;

  localparam int unsigned ITER_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  dvs_q;
  logic              neg_q;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic              done_q, done_d;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    trial_sub;
  logic              ge;
  logic [DIV_W-1:0]  quot_full;

  // one restoring step per cycle, MSB first
  always_comb begin
    trial     = {rem_q, dq_q[DIV_W-1]};
    trial_sub = trial - {1'b0, dvs_q};
    ge        = (trial >= {1'b0, dvs_q});
    dq_d      = dq_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    if (start_i) begin
      dq_d  = dividend_i;
      rem_d = '0;
      cnt_d = ITER_W'(DIV_W);
    end else if (cnt_q != '0) begin
      dq_d  = {dq_q[DIV_W-2:0], ge};
      rem_d = ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ITER_W'(1)) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
      neg_q <= negate_i;
    end
  end

  // sign fix-up; quotient is truncated toward zero
  assign quot_full = neg_q ? (~dq_q + 1'b1) : dq_q;
  assign quot_o    = quot_full[ACC_W-1:0];
  assign done_o    = done_q;

endmodule
`default_nettype wire

[hw/rtl/mls_datapath.sv]
`default_nettype none
module mls_datapath #(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // input word fields
  input  wire                            req_i,
  input  wire  [mls_pkg::CHAN_W-1:0]     chan_i,
  input  wire  [mls_pkg::LEVEL_W-1:0]    target_i,
  input  wire  [mls_pkg::DUR_W-1:0]      dur_i,
  // config
  input  wire                            cfg_we_i,
  input  wire  [mls_pkg::SPM_W-1:0]      cfg_data_i,
  // control
  input  wire  mls_pkg::mls_cmd_t        cmd_i,
  output mls_pkg::mls_sts_t              sts_o,
  // output word
  input  wire                            out_ready_i,
  output logic                           out_valid_o,
  output logic [mls_pkg::CHAN_W-1:0]     out_chan_o,
  output logic [mls_pkg::LEVEL_W-1:0]    out_level_o,
  output logic                           out_arrived_o
);
  import mls_pkg::*;

  // channels beyond the field range can never be addressed
  localparam int unsigned NCH  = (NUM_CHANNELS < CHAN_MAX) ? NUM_CHANNELS : CHAN_MAX;
  localparam int unsigned IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

  logic [SPM_W-1:0]           spm_q;
  logic                       req_q;
  logic [CHAN_W-1:0]          chan_q;
  logic signed [LEVEL_W-1:0]  tgt_q;
  logic [CNT_W-1:0]           n_q;

  logic signed [LEVEL_W-1:0]  target_q [NCH];
  logic signed [ACC_W-1:0]    acc_q    [NCH];
  logic signed [ACC_W-1:0]    step_q   [NCH];
  logic [CNT_W-1:0]           left_q   [NCH];

  logic [IDX_W-1:0]           idx;
  logic signed [DIV_W-1:0]    new_dest;
  logic signed [DIV_W-1:0]    diff;
  logic [DIV_W-1:0]           diff_mag;
  logic                       div_done;
  logic [ACC_W-1:0]           quot;

  logic signed [ACC_W-1:0]    cur_dest;
  logic signed [ACC_W-1:0]    acc_sum;
  logic                       last_tick;
  logic                       active;
  logic [LEVEL_W-1:0]         tick_level;

  logic                       out_valid_q;
  logic [CHAN_W-1:0]          out_chan_q;
  logic [LEVEL_W-1:0]         out_level_q;
  logic                       out_arrived_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spm_q <= SPM_RESET;
    end else if (cfg_we_i) begin
      spm_q <= cfg_data_i;
    end
  end

  // input capture; ramp length formed on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q  <= req_i;
      chan_q <= chan_i;
      tgt_q  <= target_i;
      n_q    <= CNT_W'(dur_i) * CNT_W'(spm_q);
    end
  end

  assign idx = chan_q[IDX_W-1:0];

  // step division setup
  always_comb begin
    new_dest = DIV_W'(tgt_q) <<< FRAC_W;
    diff     = new_dest - DIV_W'(acc_q[idx]);
    diff_mag = diff[DIV_W-1] ? (~diff + 1'b1) : diff;
  end

  mls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (diff_mag),
    .negate_i   (diff[DIV_W-1]),
    .divisor_i  (n_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // tick arithmetic
  always_comb begin
    cur_dest  = ACC_W'(target_q[idx]) <<< FRAC_W;
    acc_sum   = acc_q[idx] + step_q[idx];
    active    = (left_q[idx] != '0);
    last_tick = (left_q[idx] == CNT_W'(1));
    if (active && !last_tick) begin
      tick_level = acc_sum[ACC_W-1:FRAC_W];
    end else begin
      tick_level = target_q[idx];
    end
  end

  // per-channel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NCH; k++) begin
        target_q[k] <= '0;
        acc_q[k]    <= '0;
        step_q[k]   <= '0;
        left_q[k]   <= '0;
      end
    end else begin
      if (cmd_i.set_target) begin
        target_q[idx] <= tgt_q;
      end
      if (cmd_i.jump) begin
        acc_q[idx]  <= new_dest[ACC_W-1:0];
        step_q[idx] <= '0;
        left_q[idx] <= '0;
      end
      if (cmd_i.set_step) begin
        step_q[idx] <= quot;
        left_q[idx] <= n_q;
      end
      if (cmd_i.tick && active) begin
        if (last_tick) begin
          acc_q[idx]  <= cur_dest;
          step_q[idx] <= '0;
          left_q[idx] <= '0;
        end else begin
          acc_q[idx]  <= acc_sum;
          left_q[idx] <= left_q[idx] - 1'b1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      out_chan_q    <= chan_q;
      out_level_q   <= tick_level;
      out_arrived_q <= active && last_tick;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_chan_o    = out_chan_q;
  assign out_level_o   = out_level_q;
  assign out_arrived_o = out_arrived_q;

  // status to controller
  always_comb begin
    sts_o.is_tick  = (req_q == REQ_TICK);
    sts_o.chan_ok  = ({{(32 - CHAN_W){1'b0}}, chan_q} < 32'(NCH));
    sts_o.n_zero   = (n_q == '0);
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

[hw/rtl/mls_ctrl.sv]
`default_nettype none
module mls_ctrl (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  mls_pkg::mls_sts_t   sts_i,
  output mls_pkg::mls_cmd_t         cmd_o
);
  import mls_pkg::*;

  mls_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (!sts_i.chan_ok) begin
          state_d = ST_IDLE;
        end else if (sts_i.is_tick) begin
          state_d = ST_TICK;
        end else if (sts_i.n_zero) begin
          cmd_o.set_target = 1'b1;
          cmd_o.jump       = 1'b1;
          state_d          = ST_IDLE;
        end else begin
          cmd_o.set_target = 1'b1;
          cmd_o.div_start  = 1'b1;
          state_d          = ST_DIV;
        end
      end
      ST_TICK: begin
        // wait for room in the output register
        if (sts_i.out_free) begin
          cmd_o.tick = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.set_step = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
